// ===== rtl/ctli_pkg.sv =====
// shared constants, codes and the search token for the clamped table interpolator
package ctli_pkg;

  localparam int unsigned DefMaxEntries = 16;
  localparam int unsigned DataW         = 32;
  localparam int unsigned GapW          = DataW + 1;
  localparam int unsigned FracW         = 17;
  localparam int unsigned DivSteps      = FracW;
  localparam int unsigned DivCntW       = $clog2(DivSteps);

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // token handed from cell to cell during a search
  typedef struct packed {
    logic               found;
    logic               zero;
    logic [DataW-1:0]   q;
    logic [DataW-1:0]   lo_r;
    logic [DataW-1:0]   lo_t;
    logic [DataW-1:0]   lo_c;
    logic [DataW-1:0]   hi_r;
    logic [DataW-1:0]   hi_t;
    logic [DataW-1:0]   hi_c;
  } tok_t;

endpackage

// ===== rtl/ctli_cell.sv =====
// one table entry with its stage of the search chain
module ctli_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CntW    = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ld_en_i,
  input  logic [ctli_pkg::DataW-1:0] ld_r_i,
  input  logic [ctli_pkg::DataW-1:0] ld_t_i,
  input  logic [ctli_pkg::DataW-1:0] ld_c_i,
  input  logic [CntW-1:0]            cnt_i,
  input  logic                       tok_vld_i,
  input  ctli_pkg::tok_t             tok_i,
  input  logic [IdxW-1:0]            lo_idx_i,
  input  logic [IdxW-1:0]            hi_idx_i,
  output logic                       tok_vld_o,
  output ctli_pkg::tok_t             tok_o,
  output logic [IdxW-1:0]            lo_idx_o,
  output logic [IdxW-1:0]            hi_idx_o
);

  logic [ctli_pkg::DataW-1:0] r_q, t_q, c_q;
  logic                       tok_vld_q;
  ctli_pkg::tok_t             tok_q, tok_d;
  logic [IdxW-1:0]            lo_q, lo_d, hi_q, hi_d;
  logic                       active;

  always_ff @(posedge clk_i) begin
    if (ld_en_i) begin
      r_q <= ld_r_i;
      t_q <= ld_t_i;
      c_q <= ld_c_i;
    end
  end

  assign active = (CntW'(CellIdx) < cnt_i);

  always_comb begin
    tok_d = tok_i;
    lo_d  = lo_idx_i;
    hi_d  = hi_idx_i;
    if (active && !tok_i.found) begin
      if ($signed(r_q) >= $signed(tok_i.q)) begin
        tok_d.found = 1'b1;
        tok_d.hi_r  = r_q;
        tok_d.hi_t  = t_q;
        tok_d.hi_c  = c_q;
        hi_d        = IdxW'(CellIdx);
        // below the first entry: clamp to it
        if (CellIdx == 0) begin
          tok_d.zero = 1'b1;
          tok_d.lo_r = r_q;
          tok_d.lo_t = t_q;
          tok_d.lo_c = c_q;
          lo_d       = IdxW'(CellIdx);
        end
      end else begin
        tok_d.lo_r = r_q;
        tok_d.lo_t = t_q;
        tok_d.lo_c = c_q;
        lo_d       = IdxW'(CellIdx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;
  assign lo_idx_o  = lo_q;
  assign hi_idx_o  = hi_q;

endmodule

// ===== rtl/ctli_div.sv =====
// restoring divider, one quotient bit a cycle
module ctli_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ctli_pkg::GapW-1:0]  num_i,
  input  logic [ctli_pkg::GapW-1:0]  den_i,
  output logic                       done_o,
  output logic [ctli_pkg::FracW-1:0] quo_o
);

  logic                         run_q, done_q;
  logic [ctli_pkg::DivCntW-1:0] cnt_q;
  logic [ctli_pkg::GapW:0]      rem_q, rem_sub;
  logic [ctli_pkg::GapW-1:0]    den_q;
  logic [ctli_pkg::FracW-1:0]   quo_q;
  logic                         ge;

  assign ge      = (rem_q >= {1'b0, den_q});
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ctli_pkg::DivCntW'(ctli_pkg::DivSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= {rem_sub[ctli_pkg::GapW-1:0], 1'b0};
      quo_q <= {quo_q[ctli_pkg::FracW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/clamped_table_linear_interp_core.sv =====
// top level of the clamped piecewise-linear table interpolator
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  request  | start, busy                | command_i, entry_index_i, entry_*_i, query_radius_i
//  result   | done_o (one-cycle strobe)  | out_twist_o, out_chord_o, index_*_o, fraction_o
//  config   | cfg_valid_i, cfg_ready_o   | cfg_wdata_i (entry_count)
//
// a load request writes its cell as soon as it is taken
// a query passes in order through the registered search chain, the bit-serial fraction
//   divider (operand load, 17 quotient bits, quotient capture), a multiply step and
//   an add step, and then strobes its result
// busy is registered: it rises once a query has been accepted and stays high until
//   the result strobe; the strobe cycle itself may accept the next request
// the receiver cannot hold a result off; each strobe is taken as it comes
// reset clears control state and sets entry_count to 1; the table is undefined
//   until loaded
module clamped_table_linear_interp_core #(
  parameter int unsigned MAX_ENTRIES = ctli_pkg::DefMaxEntries,
  parameter int unsigned IdxW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int unsigned CntW        = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       command_i,
  input  logic [IdxW-1:0]            entry_index_i,
  input  logic [ctli_pkg::DataW-1:0] entry_radius_i,
  input  logic [ctli_pkg::DataW-1:0] entry_twist_i,
  input  logic [ctli_pkg::DataW-1:0] entry_chord_i,
  input  logic [ctli_pkg::DataW-1:0] query_radius_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CntW-1:0]            cfg_wdata_i,
  output logic                       done_o,
  output logic [ctli_pkg::DataW-1:0] out_twist_o,
  output logic [ctli_pkg::DataW-1:0] out_chord_o,
  output logic [IdxW-1:0]            index_low_o,
  output logic [IdxW-1:0]            index_high_o,
  output logic [ctli_pkg::FracW-1:0] fraction_o
);

  localparam int unsigned DW = ctli_pkg::DataW;
  localparam int unsigned GW = ctli_pkg::GapW;
  localparam int unsigned PW = ctli_pkg::FracW + 1 + GW;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StDiv  = 5'b00100,
    StMul  = 5'b01000,
    StAdd  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic            req_acc, is_load, is_query;
  logic [CntW-1:0] cnt_q, n_eff;

  // chain wiring, element k feeds cell k
  logic           vld_w [MAX_ENTRIES+1];
  ctli_pkg::tok_t tok_w [MAX_ENTRIES+1];
  logic [IdxW-1:0] lo_w [MAX_ENTRIES+1];
  logic [IdxW-1:0] hi_w [MAX_ENTRIES+1];
  ctli_pkg::tok_t  tok_in;

  ctli_pkg::tok_t  end_tok;
  logic            end_vld, end_zero;
  logic [IdxW-1:0] end_lo, end_hi;

  logic signed [GW-1:0] gap, num_raw;
  logic [GW-1:0]        div_num, div_den;
  logic                 div_done;
  logic [ctli_pkg::FracW-1:0] div_quo;

  // finished search, held until the result is shown
  logic [IdxW-1:0]  lo_q, hi_q;
  logic [DW-1:0]    lo_t_q, lo_c_q, hi_t_q, hi_c_q;
  logic [ctli_pkg::FracW-1:0] frac_q;
  logic [DW-1:0]    pt_q, pc_q;
  logic signed [PW-1:0] prod_t, prod_c;
  logic signed [GW-1:0] dt, dc;

  logic          done_q;
  logic [DW-1:0] tw_q, ch_q;

  assign req_acc  = start && !busy;
  assign is_load  = req_acc && (command_i == ctli_pkg::CmdLoad);
  assign is_query = req_acc && (command_i == ctli_pkg::CmdQuery);
  assign busy     = (state_q != StIdle);

  // entry_count register, clamped into 1..MAX_ENTRIES on use
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cnt_q == '0) begin
      n_eff = CntW'(1);
    end else if (cnt_q > CntW'(MAX_ENTRIES)) begin
      n_eff = CntW'(MAX_ENTRIES);
    end else begin
      n_eff = cnt_q;
    end
  end

  // fresh token enters the first cell
  always_comb begin
    tok_in       = '0;
    tok_in.q     = query_radius_i;
    tok_in.found = 1'b0;
    tok_in.zero  = 1'b0;
  end

  assign vld_w[0] = is_query;
  assign tok_w[0] = tok_in;
  assign lo_w[0]  = '0;
  assign hi_w[0]  = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    ctli_cell #(
      .CellIdx (i),
      .IdxW    (IdxW),
      .CntW    (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ld_en_i   (is_load && (entry_index_i == IdxW'(i))),
      .ld_r_i    (entry_radius_i),
      .ld_t_i    (entry_twist_i),
      .ld_c_i    (entry_chord_i),
      .cnt_i     (n_eff),
      .tok_vld_i (vld_w[i]),
      .tok_i     (tok_w[i]),
      .lo_idx_i  (lo_w[i]),
      .hi_idx_i  (hi_w[i]),
      .tok_vld_o (vld_w[i+1]),
      .tok_o     (tok_w[i+1]),
      .lo_idx_o  (lo_w[i+1]),
      .hi_idx_o  (hi_w[i+1])
    );
  end

  // end of chain: nothing found means above the last entry, clamp to it
  assign end_vld  = vld_w[MAX_ENTRIES];
  assign end_tok  = tok_w[MAX_ENTRIES];
  assign end_zero = end_tok.zero || !end_tok.found;
  assign end_lo   = lo_w[MAX_ENTRIES];
  assign end_hi   = end_tok.found ? hi_w[MAX_ENTRIES] : lo_w[MAX_ENTRIES];

  // gap and clamped numerator; a flat or falling gap, or a clamped search, divides zero by one
  assign gap     = $signed({end_tok.hi_r[DW-1], end_tok.hi_r})
                 - $signed({end_tok.lo_r[DW-1], end_tok.lo_r});
  assign num_raw = $signed({end_tok.q[DW-1], end_tok.q})
                 - $signed({end_tok.lo_r[DW-1], end_tok.lo_r});

  always_comb begin
    if (end_zero || gap[GW-1] || (gap == '0)) begin
      div_num = '0;
      div_den = GW'(1);
    end else begin
      div_den = gap;
      if (num_raw[GW-1]) begin
        div_num = '0;
      end else if (num_raw > gap) begin
        div_num = gap;
      end else begin
        div_num = num_raw;
      end
    end
  end

  ctli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (end_vld),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (end_vld) begin
      lo_q   <= end_lo;
      hi_q   <= end_tok.found ? end_hi : end_lo;
      lo_t_q <= end_tok.lo_t;
      lo_c_q <= end_tok.lo_c;
      hi_t_q <= end_tok.found ? end_tok.hi_t : end_tok.lo_t;
      hi_c_q <= end_tok.found ? end_tok.hi_c : end_tok.lo_c;
    end
  end

  // blend: low + floor(frac * (high - low) / 2^16), kept to 32 bits
  assign dt = $signed({hi_t_q[DW-1], hi_t_q}) - $signed({lo_t_q[DW-1], lo_t_q});
  assign dc = $signed({hi_c_q[DW-1], hi_c_q}) - $signed({lo_c_q[DW-1], lo_c_q});
  assign prod_t = $signed({1'b0, frac_q}) * dt;
  assign prod_c = $signed({1'b0, frac_q}) * dc;

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      frac_q <= div_quo;
    end
    if (state_q == StMul) begin
      pt_q <= prod_t[DW+15:16];
      pc_q <= prod_c[DW+15:16];
    end
    if (state_q == StAdd) begin
      tw_q <= lo_t_q + pt_q;
      ch_q <= lo_c_q + pc_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (is_query) state_d = StScan;
      StScan: if (end_vld) state_d = StDiv;
      StDiv:  if (div_done) state_d = StMul;
      StMul:  state_d = StAdd;
      StAdd:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StAdd);
    end
  end

  assign done_o       = done_q;
  assign out_twist_o  = tw_q;
  assign out_chord_o  = ch_q;
  assign index_low_o  = lo_q;
  assign index_high_o = hi_q;
  assign fraction_o   = frac_q;

  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_query |=> busy)
    else $error("query accepted without going busy");

  a_idx_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (index_low_o <= index_high_o))
    else $error("neighbour indices out of order");

  a_clamp_frac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (index_low_o == index_high_o)) |-> (fraction_o == '0))
    else $error("clamped result with non-zero fraction");

  a_frac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fraction_o <= ctli_pkg::FracW'(65536)))
    else $error("fraction above one");

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the clamped table interpolator core
module tb;

  localparam int unsigned Slots     = 16;
  localparam int unsigned TailWait  = 60;
  localparam longint      CycleCap  = 1000000;

  // prediction of the table interpolator and the queue of results still owed
  class interp_scoreboard;
    typedef struct {
      logic [31:0] twist;
      logic [31:0] chord;
      logic [3:0]  lo;
      logic [3:0]  hi;
      logic [16:0] frac;
    } interp_t;

    logic [31:0] radius[Slots];
    logic [31:0] twist_tbl[Slots];
    logic [31:0] chord_tbl[Slots];
    logic [4:0]  entry_count = 5'd1;
    interp_t     owed[$];
    int unsigned errors = 0;

    // v_lo + floor(frac * (v_hi - v_lo) / 65536)
    function logic [31:0] blend(logic [31:0] lo_v, logic [31:0] hi_v, longint frac);
      longint base;
      longint span;
      base = longint'($signed(lo_v));
      span = longint'($signed(hi_v)) - base;
      return 32'(base + ((frac * span) >>> 16));
    endfunction

    function void note_request(logic cmd, logic [3:0] idx, logic [31:0] r,
                               logic [31:0] t, logic [31:0] c, logic [31:0] q);
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      longint      frac;
      longint      r0;
      longint      gap;
      longint      num;
      interp_t     res;
      if (cmd == ctli_pkg::CmdLoad) begin
        radius[idx]    = r;
        twist_tbl[idx] = t;
        chord_tbl[idx] = c;
        return;
      end
      n = entry_count;
      if (n < 1) n = 1;
      if (n > Slots) n = Slots;
      lo = 0;
      hi = 0;
      frac = 0;
      if (n > 1) begin
        while (hi < n && $signed(radius[hi]) < $signed(q)) hi++;
        if (hi == n) begin
          hi = n - 1;
          lo = hi;
        end else if (hi > 0) begin
          lo  = hi - 1;
          r0  = longint'($signed(radius[lo]));
          gap = longint'($signed(radius[hi])) - r0;
          if (gap > 0) begin
            num = longint'($signed(q)) - r0;
            if (num < 0) num = 0;
            if (num > gap) num = gap;
            frac = (num * 65536) / gap;
          end
        end
      end
      res.twist = blend(twist_tbl[lo], twist_tbl[hi], frac);
      res.chord = blend(chord_tbl[lo], chord_tbl[hi], frac);
      res.lo    = lo[3:0];
      res.hi    = hi[3:0];
      res.frac  = frac[16:0];
      owed.push_back(res);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [31:0] twist, logic [31:0] chord, logic [3:0] lo,
                               logic [3:0] hi, logic [16:0] frac);
      interp_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %h %h %h %h %h",
                 $time, twist, chord, lo, hi, frac);
        return;
      end
      want = owed.pop_front();
      compare("out_twist", want.twist, twist);
      compare("out_chord", want.chord, chord);
      compare("index_low", 32'(want.lo), 32'(lo));
      compare("index_high", 32'(want.hi), 32'(hi));
      compare("fraction", 32'(want.frac), 32'(frac));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        command_i = ctli_pkg::CmdLoad;
  logic [3:0]  entry_index_i = '0;
  logic [31:0] entry_radius_i = '0;
  logic [31:0] entry_twist_i = '0;
  logic [31:0] entry_chord_i = '0;
  logic [31:0] query_radius_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_wdata_i = '0;
  logic        done_o;
  logic [31:0] out_twist_o;
  logic [31:0] out_chord_o;
  logic [3:0]  index_low_o;
  logic [3:0]  index_high_o;
  logic [16:0] fraction_o;

  interp_scoreboard sb = new();
  longint cycles = 0;
  bit     no_gaps = 1'b0;
  longint profile[Slots];

  clamped_table_linear_interp_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .entry_index_i (entry_index_i),
    .entry_radius_i(entry_radius_i),
    .entry_twist_i (entry_twist_i),
    .entry_chord_i (entry_chord_i),
    .query_radius_i(query_radius_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .out_twist_o   (out_twist_o),
    .out_chord_o   (out_chord_o),
    .index_low_o   (index_low_o),
    .index_high_o  (index_high_o),
    .fraction_o    (fraction_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // results are taken at the edge closing the strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(out_twist_o, out_chord_o, index_low_o, index_high_o, fraction_o);
    end
  end

  // one request: optional random hold-off, then hold start until busy is seen low
  task automatic send_request(logic cmd, logic [3:0] idx, logic [31:0] r, logic [31:0] t,
                              logic [31:0] c, logic [31:0] q);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= cmd;
    entry_index_i  <= idx;
    entry_radius_i <= r;
    entry_twist_i  <= t;
    entry_chord_i  <= c;
    query_radius_i <= q;
    do @(posedge clk_i); while (busy);
    sb.note_request(cmd, idx, r, t, c, q);
  endtask

  task automatic load_entry(logic [3:0] idx, logic [31:0] r, logic [31:0] t, logic [31:0] c);
    send_request(ctli_pkg::CmdLoad, idx, r, t, c, $urandom);
  endtask

  task automatic query(logic [31:0] q);
    send_request(ctli_pkg::CmdQuery, 4'($urandom), $urandom, $urandom, $urandom, q);
  endtask

  // drain every owed result, then let a load still in flight settle
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
  endtask

  task automatic write_count(logic [4:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.entry_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  // fresh radius profile: ascending small or large steps, duplicates, or scrambled
  task automatic load_profile();
    int unsigned style;
    longint      step_max;
    longint      acc;
    style    = $urandom_range(0, 3);
    step_max = (style == 0) ? 64'h20000 : 64'h0700_0000;
    acc      = longint'($urandom_range(0, 32'h8FFF_FFFF)) - 64'sd2147483648;
    for (int i = 0; i < Slots; i++) begin
      profile[i] = (style == 2) ? longint'($signed(32'($urandom))) : acc;
      if (style == 3 && $urandom_range(0, 2) == 0) acc = acc;
      else acc = acc + longint'($urandom_range(1, 32'(step_max)));
      load_entry(4'(i), 32'(profile[i]), $urandom, $urandom);
    end
  endtask

  initial begin
    logic [4:0]  counts[8] = '{5'd2, 5'd16, 5'd17, 5'd31, 5'd0, 5'd1, 5'd8, 5'd3};
    logic [31:0] rq;
    int unsigned k;
    int unsigned span;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme radii at both ends, twist swinging between the rails
    for (int i = 0; i < Slots; i++) begin
      load_entry(4'(i), (i == 0) ? 32'h8000_0000 : (i == 15) ? 32'h7FFF_FFFF :
                 32'((i - 8) * 32'h10_0000),
                 i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'(i * 32'h1_0000));
    end
    // single entry at reset count
    query(32'h0000_1234);
    write_count(5'd16);
    query(32'h8000_0000);          // equal to the first radius
    query(32'h7FFF_FFFF);          // equal to the last radius
    query(32'h0008_0000);          // between two entries
    query(32'hFFF0_0000);          // exactly on an entry
    query(32'h0000_0001);
    write_count(5'd4);
    query(32'h7FFF_FFFF);          // above the last used entry
    query(32'h8000_0001);
    write_count(5'd0);             // acts as one entry
    query(32'h1234_5678);
    write_count(5'd31);            // acts as the full table
    load_entry(4'd3, 32'h7000_0000, 32'h0000_0000, 32'hFFFF_FFFF);   // descending pair
    query(32'hFFA0_0000);
    query(32'h6000_0000);

    // random phases with a fresh table each time
    for (int phase = 0; phase < 12; phase++) begin
      write_count((phase < 8) ? counts[phase] : 5'($urandom_range(0, 31)));
      no_gaps = (phase % 3 == 2);
      load_profile();
      for (int j = 0; j < 85; j++) begin
        k = $urandom_range(0, Slots - 1);
        if ($urandom_range(0, 99) < 12) begin
          rq = ($urandom_range(0, 3) == 0) ? $urandom : 32'(profile[k]);
          load_entry(4'(k), rq, $urandom, $urandom);
        end else if ($urandom_range(0, 9) == 0) begin
          query($urandom);
        end else begin
          span = $urandom_range(0, 32'h0100_0000);
          query(32'(longint'($signed(sb.radius[k])) + longint'($urandom_range(0, 2 * span))
                    - longint'(span)));
        end
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
